[design/scks_pkg.sv]
`default_nettype none

package scks_pkg;

  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int SUM_W  = 23;
  localparam int IDX_W  = 6;
  localparam int REG_W  = 7;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_KSIZE  = 2'd2,
    REG_STRIDE = 2'd3
  } reg_idx_t;

  // effective (clamped) configuration plus values derived from the kernel size
  typedef struct packed {
    logic [REG_W-1:0] rows;
    logic [REG_W-1:0] cols;
    logic [REG_W-1:0] s;
    logic [REG_W-1:0] half;
    logic [REG_W-1:0] kh;
    logic [REG_W-1:0] km1;
    logic [REG_W-1:0] kr;
  } win_cfg_t;

  typedef struct packed {
    logic trig;
    logic row_end;
    logic frame_end;
  } win_flags_t;

  function automatic int pos_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int calc_iw(input int rw, input int cw);
    int xw;
    xw = (rw > cw) ? rw : cw;
    return ((xw > REG_W) ? xw : REG_W) + 2;
  endfunction

endpackage

`default_nettype wire

[design/scks_cfg_regs.sv]
`default_nettype none

module scks_cfg_regs import scks_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output win_cfg_t               cfg,
  output logic                   restart
);

  logic [REG_W-1:0] rows_r, cols_r, ksz_r, str_r;
  logic [REG_W-1:0] rows_nxt, cols_nxt, ksz_nxt, str_nxt;
  logic [REG_W-1:0] k_e;
  reg_idx_t         idx;
  logic             wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign restart = wr;

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    ksz_nxt  = ksz_r;
    str_nxt  = str_r;
    if (wr) begin
      unique case (idx)
        REG_ROWS:   rows_nxt = pwdata[REG_W-1:0];
        REG_COLS:   cols_nxt = pwdata[REG_W-1:0];
        REG_KSIZE:  ksz_nxt  = pwdata[REG_W-1:0];
        REG_STRIDE: str_nxt  = pwdata[REG_W-1:0];
        default:    rows_nxt = rows_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= REG_W'(64);
      cols_r <= REG_W'(64);
      ksz_r  <= REG_W'(3);
      str_r  <= REG_W'(1);
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      ksz_r  <= ksz_nxt;
      str_r  <= str_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROWS:   prdata = CFG_DW'(rows_r);
      REG_COLS:   prdata = CFG_DW'(cols_r);
      REG_KSIZE:  prdata = CFG_DW'(ksz_r);
      REG_STRIDE: prdata = CFG_DW'(str_r);
      default:    prdata = '0;
    endcase
  end

  // zero acts as one, frame size limited to the store
  always_comb begin
    if (rows_r == '0) begin
      cfg.rows = REG_W'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      cfg.rows = REG_W'(MAX_ROWS);
    end else begin
      cfg.rows = rows_r;
    end
    if (cols_r == '0) begin
      cfg.cols = REG_W'(1);
    end else if (32'(cols_r) > MAX_COLS) begin
      cfg.cols = REG_W'(MAX_COLS);
    end else begin
      cfg.cols = cols_r;
    end
    k_e      = (ksz_r == '0) ? REG_W'(1) : ksz_r;
    cfg.s    = (str_r == '0) ? REG_W'(1) : str_r;
    cfg.half = k_e >> 1;
    cfg.kh   = k_e - cfg.half;
    cfg.km1  = k_e - REG_W'(1);
    cfg.kr   = cfg.km1 - cfg.half;
  end

endmodule

`default_nettype wire

[design/scks_win_track.sv]
`default_nettype none

module scks_win_track import scks_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int RW = pos_bits(MAX_ROWS),
  localparam int CW = pos_bits(MAX_COLS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire win_cfg_t         cfg,
  input  wire logic             restart,
  input  wire logic             adv,
  output logic     [RW-1:0]     pos_r,
  output logic     [CW-1:0]     pos_c,
  output logic     [IDX_W-1:0]  grid_row,
  output logic     [IDX_W-1:0]  grid_col,
  output win_flags_t            flags
);

  localparam int IW = calc_iw(RW, CW);

  logic [RW-1:0]    r_r, r_nxt;
  logic [CW-1:0]    c_r, c_nxt;
  logic [REG_W-1:0] cdown_r, cdown_nxt, rdown_r, rdown_nxt;
  logic [IDX_W-1:0] orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic             fresh_r, fresh_nxt;

  logic [REG_W-1:0] cd, rd;
  logic [IDX_W-1:0] orow_v, ocol_v;
  logic [IW-1:0]    sum_kh;
  logic             col_fit, last_col, last_row;

  assign cd     = fresh_r ? cfg.half : cdown_r;
  assign rd     = fresh_r ? cfg.km1 : rdown_r;
  assign orow_v = fresh_r ? '0 : orow_r;
  assign ocol_v = fresh_r ? '0 : ocol_r;

  assign sum_kh   = IW'(c_r) + IW'(cfg.kh);
  assign col_fit  = sum_kh <= IW'(cfg.cols);
  assign last_col = (IW'(c_r) + IW'(1)) >= IW'(cfg.cols);
  assign last_row = (IW'(r_r) + IW'(1)) >= IW'(cfg.rows);

  assign flags.trig      = (cd == '0) && (rd == '0) && col_fit;
  assign flags.row_end   = (sum_kh + IW'(cfg.s)) > IW'(cfg.cols);
  assign flags.frame_end = flags.row_end &&
                           ((IW'(r_r) + IW'(cfg.s) + IW'(1)) > IW'(cfg.rows));

  assign pos_r    = r_r;
  assign pos_c    = c_r;
  assign grid_row = orow_v;
  assign grid_col = ocol_v;

  always_comb begin
    r_nxt     = r_r;
    c_nxt     = c_r;
    cdown_nxt = cdown_r;
    rdown_nxt = rdown_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    fresh_nxt = fresh_r;
    if (restart) begin
      r_nxt     = '0;
      c_nxt     = '0;
      fresh_nxt = 1'b1;
    end else if (adv) begin
      fresh_nxt = 1'b0;
      if (last_col) begin
        c_nxt     = '0;
        cdown_nxt = cfg.half;
        ocol_nxt  = '0;
        if (last_row) begin
          r_nxt     = '0;
          rdown_nxt = cfg.km1;
          orow_nxt  = '0;
        end else begin
          r_nxt = r_r + RW'(1);
          if (rd == '0) begin
            rdown_nxt = cfg.s - REG_W'(1);
            orow_nxt  = orow_v + IDX_W'(1);
          end else begin
            rdown_nxt = rd - REG_W'(1);
            orow_nxt  = orow_v;
          end
        end
      end else begin
        c_nxt     = c_r + CW'(1);
        rdown_nxt = rd;
        orow_nxt  = orow_v;
        if (cd == '0) begin
          cdown_nxt = cfg.s - REG_W'(1);
          ocol_nxt  = ocol_v + IDX_W'(1);
        end else begin
          cdown_nxt = cd - REG_W'(1);
          ocol_nxt  = ocol_v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r     <= '0;
      c_r     <= '0;
      cdown_r <= '0;
      rdown_r <= '0;
      orow_r  <= '0;
      ocol_r  <= '0;
      fresh_r <= 1'b1;
    end else begin
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      cdown_r <= cdown_nxt;
      rdown_r <= rdown_nxt;
      orow_r  <= orow_nxt;
      ocol_r  <= ocol_nxt;
      fresh_r <= fresh_nxt;
    end
  end

endmodule

`default_nettype wire

[design/scks_prefix_ram.sv]
`default_nettype none

module scks_prefix_ram #(
  parameter int AW = 12,
  parameter int DW = 23
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re0,
  input  wire logic [AW-1:0] raddr0,
  output logic      [DW-1:0] rdata0,
  input  wire logic          re1,
  input  wire logic [AW-1:0] raddr1,
  output logic      [DW-1:0] rdata1
);

  logic [DW-1:0] mem [2**AW];

  // write-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re0) begin
      rdata0 <= (we && (waddr == raddr0)) ? wdata : mem[raddr0];
    end
    if (re1) begin
      rdata1 <= (we && (waddr == raddr1)) ? wdata : mem[raddr1];
    end
  end

endmodule

`default_nettype wire

[design/scks_pixel_ram.sv]
`default_nettype none

module scks_pixel_ram #(
  parameter int AW = 12,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/strided_cross_kernel_sum.sv]
// A request that completes a window passes the P1, P2, P3 and FIN states before it is registered onto out_valid.
// Throughput: a pixel that gives no result lets the next be taken back to back; one that gives a result stalls input
// until FIN, set by the seven prefix-store reads shared over the store's two read ports; out_stall extends FIN.
// Reset clears control, configuration and raster position; neither store is cleared:
// the prefix border is produced by logic and every entry read was written earlier in the frame.
`default_nettype none

module strided_cross_kernel_sum import scks_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic        [CFG_AW-1:0]     paddr,
  input  wire logic        [CFG_DW-1:0]     pwdata,
  output logic             [CFG_DW-1:0]     prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [PIXEL_BITS-1:0] in_pixel,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed      [SUM_W-1:0]      out_cross_sum,
  output logic             [IDX_W-1:0]      out_row,
  output logic             [IDX_W-1:0]      out_col,
  output logic                              out_row_last,
  output logic                              out_frame_last
);

  localparam int RW = pos_bits(MAX_ROWS);
  localparam int CW = pos_bits(MAX_COLS);
  localparam int AW = RW + CW;
  localparam int IW = calc_iw(RW, CW);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_P1   = 5'b00010,
    ST_P2   = 5'b00100,
    ST_P3   = 5'b01000,
    ST_FIN  = 5'b10000
  } seq_st_t;

  win_cfg_t         cfg;
  logic             restart;
  logic [RW-1:0]    trk_r;
  logic [CW-1:0]    trk_c;
  logic [IDX_W-1:0] trk_orow, trk_ocol;
  win_flags_t       trk_flags;

  seq_st_t st_r, st_nxt;
  logic    accept, fin_block, fin_go;

  logic [IW-1:0] rs_w, rc_w, cs_w, cpk_w;

  // request held while its reads are in flight
  logic signed [SUM_W-1:0] it_pix_r;
  logic [RW-1:0]    it_r_r, it_rs_r, it_rc_r;
  logic [CW-1:0]    it_c_r, it_cs_r, it_cpk_r;
  logic             it_trig_r, it_r0_r, it_c0_r, it_rs0_r, it_rc0_r, it_cs0_r;
  logic             it_rend_r, it_fend_r;
  logic [IDX_W-1:0] it_orow_r, it_ocol_r;

  logic [AW-1:0]           ra0, ra1;
  logic                    re0, re1;
  logic signed [SUM_W-1:0] d0, d1;
  logic [PIXEL_BITS-1:0]   ctr_rd;

  logic signed [SUM_W-1:0] left_r, upleft_r, acc_r, acc_nxt;
  logic signed [SUM_W-1:0] up_e, left_e, upleft_e, new_sum;
  logic signed [SUM_W-1:0] a_e, b_e, c_e, e_e, f_e, ctr_e, total;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_sum_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic                    out_rlast_r, out_flast_r;

  scks_cfg_regs #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  scks_win_track #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .restart  (restart),
    .adv      (accept),
    .pos_r    (trk_r),
    .pos_c    (trk_c),
    .grid_row (trk_orow),
    .grid_col (trk_ocol),
    .flags    (trk_flags)
  );

  // sequencing
  assign fin_block = out_valid_r && out_stall;
  assign fin_go    = (st_r == ST_FIN) && !fin_block;
  assign in_stall  = ((st_r == ST_P1) && it_trig_r) || (st_r == ST_P2) ||
                     (st_r == ST_P3) || ((st_r == ST_FIN) && fin_block);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: st_nxt = accept ? ST_P1 : ST_IDLE;
      ST_P1: begin
        if (it_trig_r) begin
          st_nxt = ST_P2;
        end else begin
          st_nxt = accept ? ST_P1 : ST_IDLE;
        end
      end
      ST_P2:   st_nxt = ST_P3;
      ST_P3:   st_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_block) begin
          st_nxt = ST_FIN;
        end else begin
          st_nxt = accept ? ST_P1 : ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // window corners relative to the arriving pixel
  assign rs_w  = IW'(trk_r) - IW'(cfg.km1);
  assign rc_w  = IW'(trk_r) - IW'(cfg.kr);
  assign cs_w  = IW'(trk_c) - IW'(cfg.half);
  assign cpk_w = IW'(trk_c) + IW'(cfg.kh) - IW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_trig_r <= 1'b0;
    end else if (accept) begin
      it_trig_r <= trk_flags.trig;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_pix_r  <= SUM_W'(in_pixel);
      it_r_r    <= trk_r;
      it_c_r    <= trk_c;
      it_rs_r   <= rs_w[RW-1:0];
      it_rc_r   <= rc_w[RW-1:0];
      it_cs_r   <= cs_w[CW-1:0];
      it_cpk_r  <= cpk_w[CW-1:0];
      it_r0_r   <= trk_r == '0;
      it_c0_r   <= trk_c == '0;
      it_rs0_r  <= rs_w == '0;
      it_rc0_r  <= rc_w == '0;
      it_cs0_r  <= cs_w == '0;
      it_rend_r <= trk_flags.row_end;
      it_fend_r <= trk_flags.frame_end;
      it_orow_r <= trk_orow;
      it_ocol_r <= trk_ocol;
    end
  end

  // prefix entry (i, j) holds the sum up to and including pixel (i, j)
  always_comb begin
    ra0 = {trk_r - RW'(1), trk_c};
    ra1 = {rs_w[RW-1:0] - RW'(1), trk_c};
    if ((st_r == ST_P1) && it_trig_r) begin
      ra0 = {it_rs_r - RW'(1), it_c_r - CW'(1)};
      ra1 = {it_rc_r - RW'(1), it_cpk_r};
    end else if (st_r == ST_P2) begin
      ra0 = {it_rc_r, it_cpk_r};
      ra1 = {it_rc_r - RW'(1), it_cs_r - CW'(1)};
    end else if (st_r == ST_P3) begin
      ra0 = {it_rc_r, it_cs_r - CW'(1)};
    end
  end

  assign re0 = accept || ((st_r == ST_P1) && it_trig_r) || (st_r == ST_P2) ||
               (st_r == ST_P3);
  assign re1 = accept || ((st_r == ST_P1) && it_trig_r) || (st_r == ST_P2);

  scks_prefix_ram #(
    .AW (AW),
    .DW (SUM_W)
  ) u_prefix (
    .clk    (clk),
    .we     (st_r == ST_P1),
    .waddr  ({it_r_r, it_c_r}),
    .wdata  (new_sum),
    .re0    (re0),
    .raddr0 (ra0),
    .rdata0 (d0),
    .re1    (re1),
    .raddr1 (ra1),
    .rdata1 (d1)
  );

  scks_pixel_ram #(
    .AW (AW),
    .DW (PIXEL_BITS)
  ) u_pixel (
    .clk   (clk),
    .we    (accept),
    .waddr ({trk_r, trk_c}),
    .wdata (in_pixel),
    .re    (st_r == ST_P3),
    .raddr ({it_rc_r, it_c_r}),
    .rdata (ctr_rd)
  );

  // border row and column of the prefix table read as zero
  assign up_e     = it_r0_r ? '0 : d0;
  assign left_e   = it_c0_r ? '0 : left_r;
  assign upleft_e = it_c0_r ? '0 : upleft_r;
  assign new_sum  = up_e + left_e - upleft_e + it_pix_r;

  assign a_e   = it_rs0_r ? '0 : d1;
  assign b_e   = (it_rs0_r || it_c0_r) ? '0 : d0;
  assign c_e   = it_rc0_r ? '0 : d1;
  assign e_e   = (it_rc0_r || it_cs0_r) ? '0 : d1;
  assign f_e   = it_cs0_r ? '0 : d0;
  assign ctr_e = SUM_W'($signed(ctr_rd));
  assign total = acc_r - f_e - ctr_e;

  always_comb begin
    acc_nxt = acc_r;
    case (st_r)
      ST_P1:   acc_nxt = up_e - upleft_e + it_pix_r - a_e;
      ST_P2:   acc_nxt = acc_r + b_e - c_e;
      ST_P3:   acc_nxt = acc_r + d0 + e_e;
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (st_r == ST_P1) begin
      left_r   <= new_sum;
      upleft_r <= up_e;
    end
  end

  // output register
  assign out_valid_nxt = fin_go || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_sum_r   <= total;
      out_row_r   <= it_orow_r;
      out_col_r   <= it_ocol_r;
      out_rlast_r <= it_rend_r;
      out_flast_r <= it_fend_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cross_sum  = out_sum_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_row_last   = out_rlast_r;
  assign out_frame_last = out_flast_r;

endmodule

`default_nettype wire
